/* hw/rtl/wvr_pkg.sv */
// ----------------------------------------------------------------------------
// wvr_pkg
// Shared types and constants of the windowed vector RMS block.
// ----------------------------------------------------------------------------
package wvr_pkg;

  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int RMS_WIDTH       = 32;
  localparam int FRAC_BITS       = 16;
  localparam int COUNT_WIDTH     = 16;
  // Quotient kept ahead of the square root
  localparam int QUO_WIDTH       = 2 * RMS_WIDTH;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCEL_LSB     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GYRO_LSB      = 2'd2;

  // Register reset values
  localparam logic [CFG_DATA_WIDTH-1:0] WINDOW_LENGTH_RST = 16'd200;
  localparam logic [CFG_DATA_WIDTH-1:0] ACCEL_LSB_RST     = 16'd16384;
  localparam logic [CFG_DATA_WIDTH-1:0] GYRO_LSB_RST      = 16'd131;

  // Control from the sequencer to each lane
  typedef struct packed {
    logic square_en;
    logic accum_en;
    logic start;
  } lane_ctrl_t;

endpackage

/* hw/rtl/wvr_if.sv */
// ----------------------------------------------------------------------------
// wvr interfaces
// Sample, configuration and result channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface wvr_sample_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic signed [SAMPLE_WIDTH-1:0] rate_x;
  logic signed [SAMPLE_WIDTH-1:0] rate_y;
  logic signed [SAMPLE_WIDTH-1:0] rate_z;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  output ready);
endinterface

interface wvr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface wvr_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] accel_rms;
  logic [31:0] gyro_rms;
  logic [31:0] rms_ratio;
  logic [15:0] samples_in_window;
  modport source (output valid, accel_rms, gyro_rms, rms_ratio, samples_in_window,
                  input ready);
  modport sink   (input valid, accel_rms, gyro_rms, rms_ratio, samples_in_window,
                  output ready);
endinterface

/* hw/rtl/windowed_vector_rms.sv */
// Flow: ready drops on each sample transfer and returns once the sequencer has
// left S_ACC, unless the sample closes a window; a closing sample holds ready
// low through the lane divide and root units, the ratio divider and the result
// push, which waits for result.ready; each sample is done before another is taken.
// Reset (rst, synchronous): registers to 200/16384/131, sums and count to zero.
// ----------------------------------------------------------------------------
// windowed_vector_rms
// Windowed RMS of accelerometer and gyroscope vector magnitudes, two lanes
// and a ratio stage.
// ----------------------------------------------------------------------------
module windowed_vector_rms #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int SUM_WIDTH    = 48
) (
  input  logic         clk,
  input  logic         rst,
  wvr_sample_if.sink   sample,
  wvr_cfg_if.sink      cfg,
  wvr_result_if.source result
);
  import wvr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ACC, S_START, S_RMS, S_RATIO, S_PUSH} seq_state_t;

  seq_state_t               state;
  logic [CFG_DATA_WIDTH-1:0] window_length;
  logic [CFG_DATA_WIDTH-1:0] accel_lsb;
  logic [CFG_DATA_WIDTH-1:0] gyro_lsb;
  logic [COUNT_WIDTH-1:0]   sample_counter;
  logic [COUNT_WIDTH:0]     n;
  lane_ctrl_t               lane_ctrl;
  logic [RMS_WIDTH-1:0]     accel_rms, gyro_rms, ratio;
  logic                     accel_done, gyro_done, ratio_done;
  logic                     ratio_start;

  logic [COUNT_WIDTH-1:0]   count_next;
  logic [CFG_DATA_WIDTH-1:0] len;
  logic                     closes;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign count_next = sample_counter + 1'b1;
  assign len        = (window_length == '0) ? CFG_DATA_WIDTH'(1) : window_length;
  assign closes     = (count_next >= len) || (count_next == '0);

  assign lane_ctrl.square_en = sample.valid && sample.ready;
  assign lane_ctrl.accum_en  = (state == S_ACC);
  assign lane_ctrl.start     = (state == S_START);
  assign ratio_start         = (state == S_RMS) && accel_done && gyro_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      accel_lsb     <= ACCEL_LSB_RST;
      gyro_lsb      <= GYRO_LSB_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_WINDOW_LENGTH: window_length <= cfg.data;
        REG_ACCEL_LSB:     accel_lsb     <= cfg.data;
        REG_GYRO_LSB:      gyro_lsb      <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer, sample count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sample_counter <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (closes) begin
            sample_counter <= '0;
            n     <= (count_next == '0) ? {1'b1, {COUNT_WIDTH{1'b0}}} : {1'b0, count_next};
            state <= S_START;
          end else begin
            sample_counter <= count_next;
            state          <= S_IDLE;
          end
        end
        S_START: state <= S_RMS;
        S_RMS: begin
          if (ratio_start) begin
            state <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (ratio_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!result.valid || result.ready) begin
            result.valid             <= 1'b1;
            result.accel_rms         <= accel_rms;
            result.gyro_rms          <= gyro_rms;
            result.rms_ratio         <= ratio;
            result.samples_in_window <= n[COUNT_WIDTH-1:0];
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wvr_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .SUM_WIDTH(SUM_WIDTH)) u_accel_lane (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .axis_x (sample.accel_x),
    .axis_y (sample.accel_y),
    .axis_z (sample.accel_z),
    .n      (n),
    .lsb    (accel_lsb),
    .rms    (accel_rms),
    .done   (accel_done)
  );

  wvr_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .SUM_WIDTH(SUM_WIDTH)) u_gyro_lane (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .axis_x (sample.rate_x),
    .axis_y (sample.rate_y),
    .axis_z (sample.rate_z),
    .n      (n),
    .lsb    (gyro_lsb),
    .rms    (gyro_rms),
    .done   (gyro_done)
  );

  wvr_ratio u_ratio (
    .clk   (clk),
    .rst   (rst),
    .start (ratio_start),
    .num   (accel_rms),
    .den   (gyro_rms),
    .ratio (ratio),
    .done  (ratio_done)
  );

endmodule

/* hw/rtl/wvr_lane.sv */
// ----------------------------------------------------------------------------
// wvr_lane
// One sensor lane: squares three axes, accumulates with saturation, and at
// window end divides by n*lsb^2 (bit per cycle) and takes the square root.
// ----------------------------------------------------------------------------
module wvr_lane #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int SUM_WIDTH    = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wvr_pkg::lane_ctrl_t            ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] axis_x,
  input  logic signed [SAMPLE_WIDTH-1:0] axis_y,
  input  logic signed [SAMPLE_WIDTH-1:0] axis_z,
  input  logic [wvr_pkg::COUNT_WIDTH:0]  n,
  input  logic [wvr_pkg::CFG_DATA_WIDTH-1:0] lsb,
  output logic [wvr_pkg::RMS_WIDTH-1:0]  rms,
  output logic                           done
);
  import wvr_pkg::*;

  localparam int SQW  = 2 * SAMPLE_WIDTH;
  localparam int S3W  = SQW + 2;
  localparam int AW   = ((SUM_WIDTH > S3W) ? SUM_WIDTH : S3W) + 1;
  localparam int DVW  = SUM_WIDTH + RMS_WIDTH;
  localparam int CW   = $clog2(DVW);
  localparam int L2W  = 2 * CFG_DATA_WIDTH;
  localparam int DW   = COUNT_WIDTH + 1 + L2W;
  localparam int SCW  = $clog2(RMS_WIDTH);
  localparam int SRW  = RMS_WIDTH + 2;

  typedef enum logic [2:0] {L_IDLE, L_MUL1, L_MUL2, L_DIV, L_SQRT} lane_state_t;

  lane_state_t                    state;
  logic [SQW-1:0]                 sq_x, sq_y, sq_z;
  logic [SUM_WIDTH-1:0]           sum;
  logic [COUNT_WIDTH:0]           n_q;
  logic [CFG_DATA_WIDTH-1:0]      lsb_q;
  logic [L2W-1:0]                 lsb2;
  logic [DW-1:0]                  divisor;
  logic [DVW-1:0]                 dividend;
  logic [DW-1:0]                  rem;
  logic [QUO_WIDTH-1:0]           quo;
  logic                           over;
  logic [CW-1:0]                  div_cnt;
  logic [QUO_WIDTH-1:0]           rad;
  logic [RMS_WIDTH-1:0]           root;
  logic [SRW-1:0]                 srem;
  logic [SCW-1:0]                 sqrt_cnt;

  logic [SAMPLE_WIDTH-1:0] mag_x, mag_y, mag_z;
  logic [S3W-1:0]          sum3;
  logic [AW-1:0]           acc_wide;
  logic [SUM_WIDTH-1:0]    sum_next;
  logic [DW:0]             rem_sh, rem_diff;
  logic                    div_ge;
  logic [QUO_WIDTH-1:0]    quo_next;
  logic [SRW+1:0]          srem_sh, trial, srem_diff;
  logic                    sqrt_ge;

  // Magnitudes; the most negative value maps onto 2^(W-1) exactly
  assign mag_x = axis_x[SAMPLE_WIDTH-1] ? (~axis_x + 1'b1) : axis_x;
  assign mag_y = axis_y[SAMPLE_WIDTH-1] ? (~axis_y + 1'b1) : axis_y;
  assign mag_z = axis_z[SAMPLE_WIDTH-1] ? (~axis_z + 1'b1) : axis_z;

  // Saturating accumulate
  assign sum3     = S3W'(sq_x) + S3W'(sq_y) + S3W'(sq_z);
  assign acc_wide = AW'(sum) + AW'(sum3);
  assign sum_next = (acc_wide > AW'({SUM_WIDTH{1'b1}})) ? {SUM_WIDTH{1'b1}}
                                                        : acc_wide[SUM_WIDTH-1:0];

  // Restoring divide step
  assign rem_sh   = {rem, dividend[DVW-1]};
  assign div_ge   = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign quo_next = {quo[QUO_WIDTH-2:0], div_ge};

  // Square root step, two radicand bits a cycle
  assign srem_sh   = {srem, rad[QUO_WIDTH-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign sqrt_ge   = srem_sh >= trial;
  assign srem_diff = srem_sh - trial;

  // Squares
  always_ff @(posedge clk) begin
    if (ctrl.square_en) begin
      sq_x <= mag_x * mag_x;
      sq_y <= mag_y * mag_y;
      sq_z <= mag_z * mag_z;
    end
  end

  // Accumulator and window-end sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      if (ctrl.accum_en) begin
        sum <= sum_next;
      end
      case (state)
        L_IDLE: begin
          if (ctrl.start) begin
            n_q      <= n;
            lsb_q    <= (lsb == '0) ? CFG_DATA_WIDTH'(1) : lsb;
            dividend <= {sum, {RMS_WIDTH{1'b0}}};
            sum      <= '0;
            done     <= 1'b0;
            state    <= L_MUL1;
          end
        end
        L_MUL1: begin
          lsb2  <= lsb_q * lsb_q;
          state <= L_MUL2;
        end
        L_MUL2: begin
          divisor <= DW'(n_q) * DW'(lsb2);
          rem     <= '0;
          quo     <= '0;
          over    <= 1'b0;
          div_cnt <= CW'(DVW - 1);
          state   <= L_DIV;
        end
        L_DIV: begin
          rem      <= div_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
          dividend <= dividend << 1;
          quo      <= quo_next;
          if (div_ge && (div_cnt >= CW'(QUO_WIDTH))) begin
            over <= 1'b1;
          end
          if (div_cnt == '0) begin
            rad      <= quo_next;
            root     <= '0;
            srem     <= '0;
            sqrt_cnt <= SCW'(RMS_WIDTH - 1);
            state    <= L_SQRT;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        L_SQRT: begin
          srem <= sqrt_ge ? srem_diff[SRW-1:0] : srem_sh[SRW-1:0];
          root <= {root[RMS_WIDTH-2:0], sqrt_ge};
          rad  <= rad << 2;
          if (sqrt_cnt == '0) begin
            rms   <= over ? {RMS_WIDTH{1'b1}} : {root[RMS_WIDTH-2:0], sqrt_ge};
            done  <= 1'b1;
            state <= L_IDLE;
          end else begin
            sqrt_cnt <= sqrt_cnt - 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/wvr_ratio.sv */
// ----------------------------------------------------------------------------
// wvr_ratio
// Merging stage: accel RMS over gyro RMS in Q16.16, one quotient bit a cycle,
// zero for a zero divisor, saturating.
// ----------------------------------------------------------------------------
module wvr_ratio (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wvr_pkg::RMS_WIDTH-1:0] num,
  input  logic [wvr_pkg::RMS_WIDTH-1:0] den,
  output logic [wvr_pkg::RMS_WIDTH-1:0] ratio,
  output logic                          done
);
  import wvr_pkg::*;

  localparam int NW = RMS_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW);

  logic               busy;
  logic [NW-1:0]      dividend;
  logic [RMS_WIDTH-1:0] divisor;
  logic [RMS_WIDTH-1:0] rem;
  logic [RMS_WIDTH-1:0] quo;
  logic               over;
  logic [CW-1:0]      cnt;

  logic [RMS_WIDTH:0] rem_sh, rem_diff;
  logic               ge;

  assign rem_sh   = {rem, dividend[NW-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  // Iterate the quotient, then hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dividend <= {num, {FRAC_BITS{1'b0}}};
        divisor  <= den;
        rem      <= '0;
        quo      <= '0;
        over     <= 1'b0;
        cnt      <= CW'(NW - 1);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? rem_diff[RMS_WIDTH-1:0] : rem_sh[RMS_WIDTH-1:0];
        dividend <= dividend << 1;
        quo      <= {quo[RMS_WIDTH-2:0], ge};
        if (ge && (cnt >= CW'(RMS_WIDTH))) begin
          over <= 1'b1;
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (divisor == '0) begin
            ratio <= '0;
          end else if (over) begin
            ratio <= {RMS_WIDTH{1'b1}};
          end else begin
            ratio <= {quo[RMS_WIDTH-2:0], ge};
          end
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
